// ===== rtl/aec_pkg.sv =====
// ----------------------------------------------------------------------------
// aec_pkg
// Shared widths, register indexes, configuration struct and saturation helper
// for the axis event conditioner.
// ----------------------------------------------------------------------------
package aec_pkg;

    // raw sample width
    localparam int SAMPLE_BITS   = 16;
    // conditioned value width (Q1.15)
    localparam int VALUE_BITS    = 16;
    localparam int ELAPSED_BITS  = 16;
    localparam int MOD_BITS      = 4;
    localparam int TOL_BITS      = 16;
    localparam int DEADBAND_BITS = 16;
    localparam int GAIN_BITS     = 32;
    localparam int TIME_BITS     = 32;
    localparam int FRAC_BITS     = 16;

    // configuration port
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;

    // derived datapath widths
    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + GAIN_BITS + 1;
    localparam int Q_BITS    = PROD_BITS - FRAC_BITS;
    localparam int MAG_BITS  = (DIFF_BITS > TOL_BITS) ? DIFF_BITS : TOL_BITS;

    // Q1.15 constants
    localparam int Q15_MAX    = 32767;
    localparam int Q15_MIN    = -32768;
    localparam int Q15_OFFSET = 32768;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    // register reset values
    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(66);

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TOLERANCE        = 3'd0,
        REG_NORMALIZE_ENABLE = 3'd1,
        REG_MIN_RANGE        = 3'd2,
        REG_RANGE_GAIN       = 3'd3,
        REG_DEADBAND         = 3'd4,
        REG_INTERVAL         = 3'd5
    } cfg_index_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [TOL_BITS-1:0]             tolerance;
        logic                            normalize_enable;
        logic signed [SAMPLE_BITS-1:0]   min_range;
        logic [GAIN_BITS-1:0]            range_gain;
        logic [DEADBAND_BITS-1:0]        deadband;
        logic [TIME_BITS-1:0]            interval;
    } cfg_t;

    // clamp a wide signed value to the Q1.15 range
    function automatic logic signed [VALUE_BITS-1:0] sat_q15(
        input logic signed [Q_BITS-1:0] x
    );
        logic signed [Q_BITS-1:0] hi;
        logic signed [Q_BITS-1:0] lo;
        logic signed [VALUE_BITS-1:0] r;
        hi = Q_BITS'(Q15_MAX);
        lo = Q_BITS'(Q15_MIN);
        if (x > hi)
        begin
            r = VALUE_BITS'(hi);
        end
        else if (x < lo)
        begin
            r = VALUE_BITS'(lo);
        end
        else
        begin
            r = VALUE_BITS'(x);
        end
        return r;
    endfunction

endpackage

// ===== rtl/aec_if.sv =====
// ----------------------------------------------------------------------------
// aec channel interfaces
// Valid/ready channels for axis events, conditioned results and register
// writes.
// ----------------------------------------------------------------------------
interface aec_event_if;
    import aec_pkg::*;

    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   sample;
    logic [ELAPSED_BITS-1:0]         elapsed;
    logic [MOD_BITS-1:0]             modifier_code;

    modport source (output valid, output sample, output elapsed,
                    output modifier_code, input ready);
    modport sink   (input valid, input sample, input elapsed,
                    input modifier_code, output ready);
endinterface

interface aec_result_if;
    import aec_pkg::*;

    logic                            valid;
    logic                            ready;
    logic signed [VALUE_BITS-1:0]    value_out;
    logic [MOD_BITS-1:0]             modifier_out;

    modport source (output valid, output value_out, output modifier_out,
                    input ready);
    modport sink   (input valid, input value_out, input modifier_out,
                    output ready);
endinterface

interface aec_cfg_if;
    import aec_pkg::*;

    logic                            valid;
    logic                            ready;
    logic [CFG_IDX_BITS-1:0]         index;
    logic [CFG_DATA_BITS-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/axis_event_conditioner.sv =====
// a request passes the event register and then the result register
// throughput: one request per cycle, set by the single mapping and filter stage
// a result not taken by the receiver stalls the event register for every request
// reset (rst_n low, asynchronous) clears valid flags, the axis state and
// the time accumulator, and returns every configuration register to its reset value
// ----------------------------------------------------------------------------
// axis_event_conditioner
// Filters axis events by tolerance, maps them to Q1.15 with deadband and
// emits them once enough time has accumulated.
// ----------------------------------------------------------------------------
module axis_event_conditioner (
    input  logic          clk,
    input  logic          rst_n,
    aec_cfg_if.sink       cfg,
    aec_event_if.sink     events,
    aec_result_if.source  results
);
    import aec_pkg::*;

    cfg_t settings;

    // configuration registers
    aec_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    // event datapath
    aec_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .settings (settings),
        .events   (events),
        .results  (results)
    );

endmodule

// ===== rtl/aec_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// aec_cfg_regs
// Register file for the conditioner settings, written through the
// configuration channel; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module aec_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    aec_cfg_if.sink       cfg,
    output aec_pkg::cfg_t settings
);
    import aec_pkg::*;

    cfg_t settings_reg;
    cfg_t settings_next;

    // writes are always taken
    assign cfg.ready = 1'b1;

    // decode of one write request
    always_comb
    begin
        settings_next = settings_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_TOLERANCE:
                    settings_next.tolerance = cfg.data[TOL_BITS-1:0];
                REG_NORMALIZE_ENABLE:
                    settings_next.normalize_enable = cfg.data[0];
                REG_MIN_RANGE:
                    settings_next.min_range = $signed(cfg.data[SAMPLE_BITS-1:0]);
                REG_RANGE_GAIN:
                    settings_next.range_gain = cfg.data[GAIN_BITS-1:0];
                REG_DEADBAND:
                    settings_next.deadband = cfg.data[DEADBAND_BITS-1:0];
                REG_INTERVAL:
                    settings_next.interval = cfg.data[TIME_BITS-1:0];
                default:
                    settings_next = settings_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings_reg.tolerance        <= TOL_RESET;
            settings_reg.normalize_enable <= 1'b0;
            settings_reg.min_range        <= '0;
            settings_reg.range_gain       <= '0;
            settings_reg.deadband         <= '0;
            settings_reg.interval         <= '0;
        end
        else
        begin
            settings_reg <= settings_next;
        end
    end

    assign settings = settings_reg;

endmodule

// ===== rtl/aec_value_map.sv =====
// ----------------------------------------------------------------------------
// aec_value_map
// Maps a raw sample to a saturated Q1.15 value, through the range gain or
// straight through, and applies the deadband.
// ----------------------------------------------------------------------------
module aec_value_map (
    input  logic signed [aec_pkg::SAMPLE_BITS-1:0] sample,
    input  aec_pkg::cfg_t                          settings,
    output logic signed [aec_pkg::VALUE_BITS-1:0]  value
);
    import aec_pkg::*;

    logic signed [DIFF_BITS-1:0]  offset;
    logic signed [GAIN_BITS:0]    gain_s;
    logic signed [PROD_BITS-1:0]  product;
    logic signed [PROD_BITS-1:0]  rounded;
    logic signed [Q_BITS-1:0]     scaled;
    logic signed [Q_BITS-1:0]     normed;
    logic signed [Q_BITS-1:0]     passed;
    logic signed [VALUE_BITS-1:0] clamped;
    logic signed [VALUE_BITS:0]   clamped_x;
    logic [VALUE_BITS:0]          magnitude;

    // sample relative to the range start, exact
    assign offset = DIFF_BITS'(sample) - DIFF_BITS'(settings.min_range);
    assign gain_s = $signed({1'b0, settings.range_gain});

    // scale by the gain, round half up, drop the fraction
    assign product = PROD_BITS'(offset) * PROD_BITS'(gain_s);
    assign rounded = product + PROD_BITS'(ROUND_HALF);
    assign scaled  = rounded[PROD_BITS-1:FRAC_BITS];
    assign normed  = scaled - Q_BITS'(Q15_OFFSET);

    // raw sample read as Q1.15
    assign passed = Q_BITS'(sample);

    assign clamped = sat_q15(settings.normalize_enable ? normed : passed);

    // deadband on the magnitude
    assign clamped_x = (VALUE_BITS + 1)'(clamped);
    assign magnitude = clamped_x[VALUE_BITS] ? -clamped_x : clamped_x;

    always_comb
    begin
        if (magnitude < (VALUE_BITS + 1)'(settings.deadband))
        begin
            value = '0;
        end
        else
        begin
            value = clamped;
        end
    end

endmodule

// ===== rtl/aec_core.sv =====
// ----------------------------------------------------------------------------
// aec_core
// Event register, tolerance filter, sample and time state, and the result
// register that decouples the result channel.
// ----------------------------------------------------------------------------
module aec_core (
    input  logic          clk,
    input  logic          rst_n,
    input  aec_pkg::cfg_t settings,
    aec_event_if.sink     events,
    aec_result_if.source  results
);
    import aec_pkg::*;

    // event register
    logic                          ev_valid_reg;
    logic                          ev_valid_next;
    logic signed [SAMPLE_BITS-1:0] ev_sample_reg;
    logic [ELAPSED_BITS-1:0]       ev_elapsed_reg;
    logic [MOD_BITS-1:0]           ev_mod_reg;

    // axis state
    logic signed [SAMPLE_BITS-1:0] last_sample_reg;
    logic signed [SAMPLE_BITS-1:0] last_sample_next;
    logic                          have_last_reg;
    logic                          have_last_next;
    logic [TIME_BITS-1:0]          time_accum_reg;
    logic [TIME_BITS-1:0]          time_accum_next;

    // result register
    logic                          res_valid_reg;
    logic                          res_valid_next;
    logic signed [VALUE_BITS-1:0]  res_value_reg;
    logic [MOD_BITS-1:0]           res_mod_reg;

    logic                          ev_take;
    logic                          advance;
    logic signed [DIFF_BITS-1:0]   diff;
    logic [DIFF_BITS-1:0]          diff_mag;
    logic                          drop;
    logic [TIME_BITS:0]            time_sum;
    logic [TIME_BITS-1:0]          time_sat;
    logic                          fire;
    logic signed [VALUE_BITS-1:0]  mapped_value;

    // pipeline moves on when the result register is free or being emptied
    assign advance       = ev_valid_reg && (!res_valid_reg || results.ready);
    assign events.ready  = !ev_valid_reg || advance;
    assign ev_take       = events.valid && events.ready;

    // tolerance filter against the last kept sample
    assign diff     = DIFF_BITS'(ev_sample_reg) - DIFF_BITS'(last_sample_reg);
    assign diff_mag = diff[DIFF_BITS-1] ? -diff : diff;
    assign drop     = have_last_reg &&
                      (MAG_BITS'(diff_mag) < MAG_BITS'(settings.tolerance));

    // value mapping
    aec_value_map u_value_map (
        .sample   (ev_sample_reg),
        .settings (settings),
        .value    (mapped_value)
    );

    // time accumulation with saturation
    assign time_sum = {1'b0, time_accum_reg} + (TIME_BITS + 1)'(ev_elapsed_reg);
    assign time_sat = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];
    assign fire     = !drop && (time_sat >= settings.interval);

    // next state
    always_comb
    begin
        last_sample_next = last_sample_reg;
        have_last_next   = have_last_reg;
        time_accum_next  = time_accum_reg;
        if (advance && !drop)
        begin
            last_sample_next = ev_sample_reg;
            have_last_next   = 1'b1;
            time_accum_next  = fire ? (time_sat - settings.interval) : time_sat;
        end
    end

    // valid flags
    always_comb
    begin
        if (ev_take)
        begin
            ev_valid_next = 1'b1;
        end
        else if (advance)
        begin
            ev_valid_next = 1'b0;
        end
        else
        begin
            ev_valid_next = ev_valid_reg;
        end

        if (advance && fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            last_sample_reg <= '0;
            have_last_reg   <= 1'b0;
            time_accum_reg  <= '0;
        end
        else
        begin
            ev_valid_reg    <= ev_valid_next;
            res_valid_reg   <= res_valid_next;
            last_sample_reg <= last_sample_next;
            have_last_reg   <= have_last_next;
            time_accum_reg  <= time_accum_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ev_take)
        begin
            ev_sample_reg  <= events.sample;
            ev_elapsed_reg <= events.elapsed;
            ev_mod_reg     <= events.modifier_code;
        end
        if (advance && fire)
        begin
            res_value_reg <= mapped_value;
            res_mod_reg   <= ev_mod_reg;
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.value_out    = res_value_reg;
    assign results.modifier_out = res_mod_reg;

    // a dropped event leaves the axis state alone
    a_drop_keeps_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && drop |=> $stable(last_sample_reg) && $stable(time_accum_reg)
    ) else $error("dropped event changed axis state");

    // a kept event arms the tolerance filter
    a_kept_sets_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && !drop |=> have_last_reg
    ) else $error("kept event did not set have_last");

    // a firing event lands in the result register
    a_fire_loads_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && fire |=> res_valid_reg && res_value_reg == $past(mapped_value)
    ) else $error("fired value not held in result register");

    // an empty event register always takes a request
    a_empty_is_ready: assert property (
        @(posedge clk) disable iff (!rst_n)
        !ev_valid_reg |-> events.ready
    ) else $error("event register empty but not ready");

endmodule
